### design/xtrc_pkg.sv
// Package: shared types and constants of the xor trie range counter.
package xtrc_pkg;

    // Field widths of one transfer
    localparam int FIELD_W = 31;
    localparam int COUNT_W = 32;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CMD,
        S_C_RD,
        S_C_EV,
        S_INS_DEC,
        S_I_RD,
        S_I_EV,
        S_I_INC,
        S_I_POP,
        S_I_LINK,
        S_R_BEGIN,
        S_R_RD,
        S_R_EV,
        S_R_DEC,
        S_Q_RD,
        S_Q_EV,
        S_Q_ADD,
        S_Q_STEP,
        S_DONE
    } t_state;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_LINK_RD,
        OP_STEP,
        OP_MISS,
        OP_ROOT_INC,
        OP_ROOT_DEC,
        OP_CNT_RD,
        OP_INC,
        OP_POP_RD,
        OP_POP_WR,
        OP_LINK_WR,
        OP_DEC,
        OP_QCNT_RD,
        OP_ADD,
        OP_QSTEP,
        OP_RESULT
    } t_op;

    // Controller to datapath
    typedef struct packed {
        t_op     op;
        t_status code;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       nx_zero;
        logic       last;
        logic       full;
        logic       lim_bit;
        logic       same_zero;
        logic       q_stop;
    } t_sts;

endpackage

### design/xtrc_if.sv
// Interfaces: request and result channels of the xor trie range counter.
interface xtrc_in_if import xtrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [FIELD_W-1:0] key_value;
    logic [FIELD_W-1:0] xor_mask;
    logic [FIELD_W-1:0] upper_limit;

    modport source (output valid, command, key_value, xor_mask, upper_limit, input ready);
    modport sink   (input valid, command, key_value, xor_mask, upper_limit, output ready);
endinterface

interface xtrc_out_if import xtrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;
    logic [1:0]         status;

    modport source (output valid, match_count, status, input ready);
    modport sink   (input valid, match_count, status, output ready);
endinterface

### design/xtrc_ram.sv
// Generic single write port RAM with registered read.
module xtrc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds while idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/xtrc_ctrl.sv
// Controller: sequences the trie walks of insert, remove and query.
module xtrc_ctrl import xtrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_out_valid, n_out_valid;
    logic    slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CMD;
            end
            S_CMD: begin
                n_code = ST_OK;
                case (i_sts.cmd)
                    CMD_INSERT, CMD_REMOVE: n_state = S_C_RD;
                    CMD_QUERY:              n_state = S_Q_RD;
                    default:                n_state = S_DONE;
                endcase
            end
            S_C_RD: n_state = S_C_EV;
            S_C_EV: begin
                if (i_sts.nx_zero) begin
                    if (i_sts.cmd == CMD_INSERT) begin
                        n_state = S_INS_DEC;
                    end else begin
                        n_code  = ST_ABSENT;
                        n_state = S_DONE;
                    end
                end else if (i_sts.last) begin
                    n_state = (i_sts.cmd == CMD_INSERT) ? S_INS_DEC : S_R_BEGIN;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_INS_DEC: begin
                if (i_sts.full) begin
                    n_code  = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_I_RD;
                end
            end
            S_I_RD: n_state = S_I_EV;
            S_I_EV: n_state = i_sts.nx_zero ? S_I_POP : S_I_INC;
            S_I_INC: n_state = i_sts.last ? S_DONE : S_I_RD;
            S_I_POP: n_state = S_I_LINK;
            S_I_LINK: n_state = i_sts.last ? S_DONE : S_I_RD;
            S_R_BEGIN: n_state = S_R_RD;
            S_R_RD: n_state = S_R_EV;
            S_R_EV: n_state = S_R_DEC;
            S_R_DEC: n_state = i_sts.last ? S_DONE : S_R_RD;
            S_Q_RD: n_state = S_Q_EV;
            S_Q_EV: begin
                if (i_sts.lim_bit && !i_sts.same_zero) n_state = S_Q_ADD;
                else if (i_sts.q_stop || i_sts.last)   n_state = S_DONE;
                else                                   n_state = S_Q_STEP;
            end
            S_Q_ADD: n_state = (i_sts.q_stop || i_sts.last) ? S_DONE : S_Q_STEP;
            S_Q_STEP: n_state = S_Q_RD;
            S_DONE: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_ctl.op   = OP_NONE;
        o_ctl.code = r_code;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.op = OP_START;
            end
            S_C_RD, S_I_RD, S_R_RD, S_Q_RD: o_ctl.op = OP_LINK_RD;
            S_C_EV: begin
                if (!i_sts.nx_zero)                 o_ctl.op = OP_STEP;
                else if (i_sts.cmd == CMD_INSERT)   o_ctl.op = OP_MISS;
            end
            S_INS_DEC: begin
                if (!i_sts.full) o_ctl.op = OP_ROOT_INC;
            end
            S_I_EV:    o_ctl.op = i_sts.nx_zero ? OP_POP_RD : OP_CNT_RD;
            S_I_INC:   o_ctl.op = OP_INC;
            S_I_POP:   o_ctl.op = OP_POP_WR;
            S_I_LINK:  o_ctl.op = OP_LINK_WR;
            S_R_BEGIN: o_ctl.op = OP_ROOT_DEC;
            S_R_EV:    o_ctl.op = OP_CNT_RD;
            S_R_DEC:   o_ctl.op = OP_DEC;
            S_Q_EV: begin
                if (i_sts.lim_bit && !i_sts.same_zero) o_ctl.op = OP_QCNT_RD;
            end
            S_Q_ADD:  o_ctl.op = OP_ADD;
            S_Q_STEP: o_ctl.op = OP_QSTEP;
            S_DONE: begin
                if (slot_free) o_ctl.op = OP_RESULT;
            end
            default: o_ctl.op = OP_NONE;
        endcase
    end

    // Result slot
    always_comb begin
        n_out_valid = (r_out_valid && !i_out_ready) || (o_ctl.op == OP_RESULT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

### design/xtrc_dp.sv
// Datapath: node tables, free stack, root node and walk registers.
module xtrc_dp import xtrc_pkg::*; #(
    parameter int KEY_BITS = 31,
    parameter int NODES    = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    output t_sts               o_sts,
    input  logic [1:0]         i_command,
    input  logic [FIELD_W-1:0] i_key_value,
    input  logic [FIELD_W-1:0] i_xor_mask,
    input  logic [FIELD_W-1:0] i_upper_limit,
    output logic [COUNT_W-1:0] o_match_count,
    output logic [1:0]         o_status
);
    localparam int NB    = $clog2(NODES);
    localparam int FT_W  = $clog2(NODES + 1);
    localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int MW    = $clog2(KEY_BITS + 1);
    localparam int CW    = (FT_W > MW) ? FT_W : MW;
    localparam logic [FT_W-1:0] TOP_INIT = FT_W'(NODES - 1);
    localparam logic [FT_W-1:0] TOP_FULL = FT_W'(NODES);

    // Request registers
    logic [1:0]          r_cmd;
    logic [KEY_BITS-1:0] r_key, r_mask, r_lim;
    // Walk registers
    logic [NB-1:0]       r_cur, r_nx;
    logic [LVL_W-1:0]    r_lvl;
    logic [MW-1:0]       r_missing;
    logic [COUNT_W-1:0]  r_total;
    // Root node
    logic [NB-1:0]       r_root_zl, r_root_ol;
    logic [COUNT_W-1:0]  r_root_cnt;
    // Free stack, with low-water mark of positions never written
    logic [FT_W-1:0]     r_top, r_low, r_pos;
    logic                r_fresh;
    // Result
    logic [COUNT_W-1:0]  r_res_cnt;
    logic [1:0]          r_res_st;

    // Memory ports
    logic               lk_re, cnt_re, stk_re;
    logic               zl_we, ol_we, cnt_we, stk_we;
    logic [NB-1:0]      rd_addr, lk_waddr, cnt_waddr, stk_raddr, stk_waddr;
    logic [NB-1:0]      lk_wdata, stk_wdata;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [NB-1:0]      zl_rd, ol_rd, stk_rd;
    logic [COUNT_W-1:0] cnt_rd;

    // Walk decode
    logic [NB-1:0]      link_z, link_o, nx, same, diff, pop_n;
    logic               b, xb, lb, at_root, fresh;
    logic [FT_W-1:0]    pos_pop;
    logic [COUNT_W-1:0] cnt_m1;
    logic [2*KEY_BITS+FIELD_W-1:0] ext_key, ext_mask, ext_lim;

    assign ext_key  = {{(2*KEY_BITS){1'b0}}, i_key_value};
    assign ext_mask = {{(2*KEY_BITS){1'b0}}, i_xor_mask};
    assign ext_lim  = {{(2*KEY_BITS){1'b0}}, i_upper_limit};

    assign at_root = (r_cur == '0);
    assign link_z  = at_root ? r_root_zl : zl_rd;
    assign link_o  = at_root ? r_root_ol : ol_rd;
    assign b       = r_key[r_lvl];
    assign xb      = r_mask[r_lvl];
    assign lb      = r_lim[r_lvl];
    assign nx      = b ? link_o : link_z;
    assign same    = xb ? link_o : link_z;
    assign diff    = xb ? link_z : link_o;
    assign cnt_m1  = cnt_rd - 1'b1;
    assign pos_pop = r_top - 1'b1;
    assign fresh   = (pos_pop < r_low);
    assign pop_n   = r_fresh ? NB'(r_pos + 1'b1) : stk_rd;

    // Status to controller
    assign o_sts.cmd       = r_cmd;
    assign o_sts.nx_zero   = (nx == '0);
    assign o_sts.last      = (r_lvl == '0);
    assign o_sts.full      = (CW'(r_missing) > CW'(r_top)) || (r_root_cnt == '1);
    assign o_sts.lim_bit   = lb;
    assign o_sts.same_zero = (same == '0);
    assign o_sts.q_stop    = lb ? (diff == '0) : (same == '0);

    // Memory port control
    always_comb begin
        lk_re     = 1'b0;
        cnt_re    = 1'b0;
        stk_re    = 1'b0;
        zl_we     = 1'b0;
        ol_we     = 1'b0;
        cnt_we    = 1'b0;
        stk_we    = 1'b0;
        rd_addr   = r_cur;
        lk_waddr  = r_cur;
        lk_wdata  = '0;
        cnt_waddr = r_nx;
        cnt_wdata = cnt_rd + 1'b1;
        stk_raddr = pos_pop[NB-1:0];
        stk_waddr = r_top[NB-1:0];
        stk_wdata = r_nx;
        case (i_ctl.op)
            OP_LINK_RD: lk_re = 1'b1;
            OP_CNT_RD: begin
                cnt_re  = 1'b1;
                rd_addr = nx;
            end
            OP_QCNT_RD: begin
                cnt_re  = 1'b1;
                rd_addr = same;
            end
            OP_INC: cnt_we = 1'b1;
            OP_POP_RD: stk_re = 1'b1;
            OP_POP_WR: begin
                zl_we     = 1'b1;
                ol_we     = 1'b1;
                lk_waddr  = pop_n;
                cnt_we    = 1'b1;
                cnt_waddr = pop_n;
                cnt_wdata = COUNT_W'(1);
            end
            OP_LINK_WR: begin
                lk_wdata = r_nx;
                zl_we    = !at_root && !b;
                ol_we    = !at_root && b;
            end
            OP_DEC: begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_m1;
                if (cnt_m1 == '0) begin
                    zl_we  = !at_root && !b;
                    ol_we  = !at_root && b;
                    stk_we = (r_top < TOP_FULL);
                end
            end
            default: ;
        endcase
    end

    // Walk and root registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_START: begin
                r_cmd     <= i_command;
                r_key     <= ext_key[KEY_BITS-1:0];
                r_mask    <= ext_mask[KEY_BITS-1:0];
                r_lim     <= ext_lim[KEY_BITS-1:0];
                r_cur     <= '0;
                r_lvl     <= LVL_W'(KEY_BITS - 1);
                r_missing <= '0;
                r_total   <= '0;
            end
            OP_STEP: begin
                r_cur <= nx;
                r_lvl <= r_lvl - 1'b1;
            end
            OP_MISS: r_missing <= MW'(r_lvl) + 1'b1;
            OP_ROOT_INC, OP_ROOT_DEC: begin
                r_cur <= '0;
                r_lvl <= LVL_W'(KEY_BITS - 1);
            end
            OP_CNT_RD: r_nx <= nx;
            OP_INC: begin
                r_cur <= r_nx;
                r_lvl <= r_lvl - 1'b1;
            end
            OP_POP_RD: begin
                r_fresh <= fresh;
                r_pos   <= pos_pop;
            end
            OP_POP_WR: r_nx <= pop_n;
            OP_LINK_WR, OP_DEC: begin
                r_cur <= r_nx;
                r_lvl <= r_lvl - 1'b1;
            end
            OP_ADD: r_total <= r_total + cnt_rd;
            OP_QSTEP: begin
                r_cur <= lb ? diff : same;
                r_lvl <= r_lvl - 1'b1;
            end
            OP_RESULT: begin
                r_res_cnt <= r_total;
                r_res_st  <= i_ctl.code;
            end
            default: ;
        endcase
    end

    // Root node and free stack pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_zl  <= '0;
            r_root_ol  <= '0;
            r_root_cnt <= '0;
            r_top      <= TOP_INIT;
            r_low      <= TOP_INIT;
        end else begin
            case (i_ctl.op)
                OP_ROOT_INC: r_root_cnt <= r_root_cnt + 1'b1;
                OP_ROOT_DEC: r_root_cnt <= r_root_cnt - 1'b1;
                OP_POP_WR: begin
                    if (r_top != '0) begin
                        r_top <= pos_pop;
                        if (r_fresh) r_low <= r_pos;
                    end
                end
                OP_LINK_WR: begin
                    if (at_root && !b) r_root_zl <= r_nx;
                    if (at_root && b)  r_root_ol <= r_nx;
                end
                OP_DEC: begin
                    if (cnt_m1 == '0) begin
                        if (at_root && !b) r_root_zl <= '0;
                        if (at_root && b)  r_root_ol <= '0;
                        if (r_top < TOP_FULL) r_top <= r_top + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Node tables and free stack
    xtrc_ram #(.WIDTH(NB), .DEPTH(NODES)) u_zero_link (
        .i_clk(i_clk), .i_we(zl_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_re(lk_re), .i_raddr(rd_addr), .o_rdata(zl_rd)
    );
    xtrc_ram #(.WIDTH(NB), .DEPTH(NODES)) u_one_link (
        .i_clk(i_clk), .i_we(ol_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_re(lk_re), .i_raddr(rd_addr), .o_rdata(ol_rd)
    );
    xtrc_ram #(.WIDTH(COUNT_W), .DEPTH(NODES)) u_below_count (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_re(cnt_re), .i_raddr(rd_addr), .o_rdata(cnt_rd)
    );
    xtrc_ram #(.WIDTH(NB), .DEPTH(NODES)) u_free_nodes (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_rd)
    );

    assign o_match_count = r_res_cnt;
    assign o_status      = r_res_st;
endmodule

### design/xor_trie_range_counter_core.sv
// Top level: xor trie range counter, controller plus datapath.
// Keeps a multiset of KEY_BITS-bit keys in a binary trie of NODES nodes and
// answers insert, remove and count-under-xor requests, one result transfer per
// request. One request is worked on at a time; the next is taken while the
// previous result waits in the output register. The node tables are RAMs with
// one write port and registered read, and each trie level costs a link read
// plus a count read or update. A query makes one walk; a remove makes a check
// walk then an update walk; an insert makes a check walk, then a link read, a
// count read and an increment per existing node, or a link read, a stack read,
// a node write and a link write per new node. No clearing pass follows reset:
// the free stack is tracked by a low-water mark, so the block is ready at once.
module xor_trie_range_counter_core import xtrc_pkg::*; #(
    parameter int KEY_BITS = 31,
    parameter int NODES    = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xtrc_in_if.sink    i_in,
    xtrc_out_if.source o_out
);
    t_ctl ctl;
    t_sts sts;

    // Sequencer
    xtrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Trie storage and arithmetic
    xtrc_dp #(.KEY_BITS(KEY_BITS), .NODES(NODES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_command     (i_in.command),
        .i_key_value   (i_in.key_value),
        .i_xor_mask    (i_in.xor_mask),
        .i_upper_limit (i_in.upper_limit),
        .o_match_count (o_out.match_count),
        .o_status      (o_out.status)
    );
endmodule
